### hw/rtl/assert_macros.svh
// Assertion helpers for the RTL. Both expect clk_i in scope; RMS_ASSERT also rst_ni.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every edge outside reset
`define RMS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check a property on every edge, reset included
`define RMS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

### hw/rtl/rms_pkg.sv
package rms_pkg;

  localparam int OP_W          = 3;
  localparam int SLEEP_W       = 16;
  localparam int CFG_W         = 8;
  localparam int TASK_ID_W     = 2;
  localparam int COUNT_W       = 3;
  localparam int MASK_W        = 4;
  localparam int CFG_IDX_W     = 3;
  localparam int NUM_CFG_TASKS = 3;

  typedef logic [TASK_ID_W-1:0] task_id_t;
  typedef logic [NUM_CFG_TASKS-1:0][CFG_W-1:0] cfg_bank_t;

  typedef enum logic [OP_W-1:0] {
    OP_START    = 3'd0,
    OP_TICK     = 3'd1,
    OP_JOB_DONE = 3'd2,
    OP_SLEEP    = 3'd3,
    OP_EXIT     = 3'd4
  } rms_op_e;

  typedef enum logic [1:0] {
    TS_READY   = 2'd0,
    TS_RUNNING = 2'd1,
    TS_BLOCKED = 2'd2
  } rms_status_e;

  // Register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_PERIOD1 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PERIOD2 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PERIOD3 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BUDGET1 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_BUDGET2 = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_BUDGET3 = 3'd5;

  localparam cfg_bank_t PERIOD_RST = {8'd30, 8'd20, 8'd10};
  localparam cfg_bank_t BUDGET_RST = {8'd8, 8'd5, 8'd2};

  // Per-task counters and status
  typedef struct packed {
    logic [SLEEP_W-1:0] sleep;
    logic [CFG_W-1:0]   period;
    logic [CFG_W-1:0]   budget;
    rms_status_e        status;
  } rms_task_t;

  localparam rms_task_t TASK_RST = '{sleep: '0, period: '0, budget: '0, status: TS_READY};

  typedef enum logic {
    TU_WALK,
    TU_CHARGE
  } rms_tu_mode_e;

  typedef enum logic [2:0] {
    L_NOP,
    L_CLEAR,
    L_INSERT,
    L_POP,
    L_SORT
  } rms_list_op_e;

  typedef struct packed {
    rms_list_op_e op;
    logic         odd;
    task_id_t     id;
  } rms_list_cmd_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CLEAR,
    S_LOAD,
    S_WALK,
    S_CHARGE,
    S_REMOVE,
    S_REQUEUE,
    S_SORT,
    S_PICK,
    S_DONE
  } rms_state_e;

  // Look up a task's register; the idle slot reads zero
  function automatic logic [CFG_W-1:0] task_cfg(input cfg_bank_t bank, input task_id_t id);
    logic [CFG_W-1:0] val;
    case (id)
      2'd1:    val = bank[0];
      2'd2:    val = bank[1];
      2'd3:    val = bank[2];
      default: val = '0;
    endcase
    return val;
  endfunction

endpackage

### hw/rtl/rms_if.sv
interface rms_in_if;
  import rms_pkg::*;

  logic               valid;
  logic               ready;
  logic [OP_W-1:0]    op;
  logic [SLEEP_W-1:0] sleep_ticks;

  modport source (output valid, op, sleep_ticks, input ready);
  modport sink   (input valid, op, sleep_ticks, output ready);
endinterface

interface rms_out_if;
  import rms_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [TASK_ID_W-1:0] running_task;
  logic [COUNT_W-1:0]   ready_count;
  logic [MASK_W-1:0]    blocked_mask;

  modport source (output valid, running_task, ready_count, blocked_mask, input ready);
  modport sink   (input valid, running_task, ready_count, blocked_mask, output ready);
endinterface

### hw/rtl/rms_tunit.sv
// Shared task update unit: one task slot per use, either a tick walk step
// (sleep and period countdown, release) or a budget charge.
module rms_tunit (
  input  rms_pkg::rms_tu_mode_e     mode_i,
  input  rms_pkg::rms_task_t        task_i,
  input  logic                      is_cur_i,
  input  logic [rms_pkg::CFG_W-1:0] period_i,
  input  logic [rms_pkg::CFG_W-1:0] budget_i,
  output rms_pkg::rms_task_t        task_o,
  output logic                      insert_o
);
  import rms_pkg::*;

  always_comb begin
    task_o   = task_i;
    insert_o = 1'b0;
    case (mode_i)
      TU_WALK: begin
        // count down sleep, wake a blocked task at zero
        if (task_i.sleep != '0) begin
          task_o.sleep = task_i.sleep - SLEEP_W'(1);
          if (task_o.sleep == '0 && task_i.status == TS_BLOCKED) begin
            task_o.status = TS_READY;
            insert_o      = 1'b1;
          end
        end
        // count down period, reload and release at expiry
        if (task_i.period != '0) begin
          task_o.period = task_i.period - CFG_W'(1);
          if (task_o.period == '0) begin
            task_o.period = period_i;
            task_o.budget = budget_i;
            if (!is_cur_i && task_o.status != TS_READY) begin
              task_o.status = TS_READY;
              insert_o      = 1'b1;
            end
          end
        end
      end
      TU_CHARGE: begin
        // charge one tick, block when the budget runs out
        if (task_i.budget != '0) begin
          task_o.budget = task_i.budget - CFG_W'(1);
          if (task_o.budget == '0) begin
            task_o.status = TS_BLOCKED;
          end
        end
      end
      default: begin
        task_o = task_i;
      end
    endcase
  end

endmodule

### hw/rtl/rms_rlist.sv
// Ready list: append at the tail, drop the head, and one odd-even
// transposition pass per sort command (stable by period, strict compare).
module rms_rlist #(
  parameter int TASK_SLOTS = 4
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  rms_pkg::rms_list_cmd_t      cmd_i,
  input  rms_pkg::cfg_bank_t          periods_i,
  output rms_pkg::task_id_t           head_o,
  output logic [rms_pkg::COUNT_W-1:0] len_o
);
  import rms_pkg::*;

  localparam int IDX_W = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;

  task_id_t           ent_q [TASK_SLOTS];
  task_id_t           ent_d [TASK_SLOTS];
  logic [COUNT_W-1:0] len_q, len_d;
  logic [CFG_W-1:0]   prio [TASK_SLOTS];

  // Look up each entry's period
  always_comb begin
    for (int k = 0; k < TASK_SLOTS; k++) begin
      prio[k] = task_cfg(periods_i, ent_q[k]);
    end
  end

  always_comb begin
    ent_d = ent_q;
    len_d = len_q;
    case (cmd_i.op)
      L_CLEAR: begin
        len_d = '0;
      end
      L_INSERT: begin
        // drop the word when the list is full
        if (len_q < COUNT_W'(TASK_SLOTS)) begin
          ent_d[len_q[IDX_W-1:0]] = cmd_i.id;
          len_d = len_q + COUNT_W'(1);
        end
      end
      L_POP: begin
        if (len_q != '0) begin
          for (int k = 0; k < TASK_SLOTS - 1; k++) begin
            ent_d[k] = ent_q[k + 1];
          end
          len_d = len_q - COUNT_W'(1);
        end
      end
      L_SORT: begin
        // swap out-of-order neighbors of one parity
        for (int k = 0; k < TASK_SLOTS - 1; k++) begin
          if ((k % 2) == int'(cmd_i.odd) && (k + 1) < int'(len_q) &&
              prio[k] > prio[k + 1]) begin
            ent_d[k]     = ent_q[k + 1];
            ent_d[k + 1] = ent_q[k];
          end
        end
      end
      default: begin
        len_d = len_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    ent_q <= ent_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= '0;
    end else begin
      len_q <= len_d;
    end
  end

  assign head_o = ent_q[0];
  assign len_o  = len_q;

endmodule

### hw/rtl/rate_monotonic_task_scheduler.sv
// Channel  Dir  Handshake     Word
// req_i    in   valid/ready   op, sleep_ticks
// rsp_o    out  valid/ready   running_task, ready_count, blocked_mask
//
// One word in, one word out (TASK_SLOTS = N). A tick walks the task slots, charges
// the running task, removes and requeues it, sorts and picks; start clears, loads and
// sorts; a switching job done/sleep/exit removes, requeues, sorts and picks. The shared
// task unit walks one slot a cycle and the sort takes N odd-even passes. Reset clears all counters and the list length.
// A result waiting on rsp_o does not stop the next accept; it only holds
// the final step of the following word.
`include "assert_macros.svh"

module rate_monotonic_task_scheduler #(
  parameter int TASK_SLOTS = 4
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  rms_in_if.sink                        req_i,
  rms_out_if.source                     rsp_o,
  input  logic                          cfg_we_i,
  input  logic [rms_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [rms_pkg::CFG_W-1:0]     cfg_data_i
);
  import rms_pkg::*;

  localparam int IDX_W = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;

  rms_state_e         state_q, state_d;
  logic [IDX_W-1:0]   cnt_q, cnt_d;
  logic [IDX_W-1:0]   sel;
  logic               last;
  logic               from_start_q;
  task_id_t           cur_q;
  task_id_t           sel_id;
  task_id_t           pick_id;
  cfg_bank_t          period_q, budget_q;
  rms_task_t          tasks_q [TASK_SLOTS];
  rms_task_t          sel_task, unit_task;
  logic               unit_ins;
  rms_tu_mode_e       tu_mode;
  rms_list_cmd_t      lcmd;
  task_id_t           head;
  logic [COUNT_W-1:0] len;
  logic [MASK_W-1:0]  mask;
  rms_op_e            op_e;
  logic               in_acc;
  logic               out_load;
  logic               out_valid_q;
  task_id_t           out_task_q;
  logic [COUNT_W-1:0] out_count_q;
  logic [MASK_W-1:0]  out_mask_q;
  logic               idle_run;
  rms_status_e        cur_status;

  assign op_e     = rms_op_e'(req_i.op);
  assign in_acc   = req_i.valid && req_i.ready;
  assign last     = (cnt_q == IDX_W'(TASK_SLOTS - 1));
  assign out_load = (state_q == S_DONE) && (!out_valid_q || rsp_o.ready);

  // Load and walk steps address the slot counter, everything else the running task
  assign sel      = (state_q == S_LOAD || state_q == S_WALK) ? cnt_q : cur_q[IDX_W-1:0];
  assign sel_id   = TASK_ID_W'(sel);
  assign sel_task = tasks_q[sel];
  assign pick_id  = (len != '0) ? head : '0;

  rms_tunit u_tunit (
    .mode_i   (tu_mode),
    .task_i   (sel_task),
    .is_cur_i (sel_id == cur_q),
    .period_i (task_cfg(period_q, sel_id)),
    .budget_i (task_cfg(budget_q, sel_id)),
    .task_o   (unit_task),
    .insert_o (unit_ins)
  );

  rms_rlist #(
    .TASK_SLOTS (TASK_SLOTS)
  ) u_rlist (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (lcmd),
    .periods_i (period_q),
    .head_o    (head),
    .len_o     (len)
  );

  // Next state and step counter
  always_comb begin
    state_d = state_q;
    cnt_d   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          case (op_e)
            OP_START: state_d = S_CLEAR;
            OP_TICK: begin
              state_d = S_WALK;
              cnt_d   = IDX_W'(1);
            end
            OP_JOB_DONE: state_d = (sel_task.status == TS_RUNNING) ? S_REMOVE : S_DONE;
            OP_SLEEP:    state_d = (req_i.sleep_ticks != '0) ? S_REMOVE : S_DONE;
            OP_EXIT:     state_d = S_REMOVE;
            default:     state_d = S_DONE;
          endcase
        end
      end
      S_CLEAR: begin
        state_d = S_LOAD;
        cnt_d   = IDX_W'(1);
      end
      S_LOAD: begin
        state_d = last ? S_SORT : S_LOAD;
        cnt_d   = last ? '0 : cnt_q + IDX_W'(1);
      end
      S_WALK: begin
        state_d = last ? S_CHARGE : S_WALK;
        cnt_d   = last ? '0 : cnt_q + IDX_W'(1);
      end
      S_CHARGE:  state_d = S_REMOVE;
      S_REMOVE:  state_d = (cur_q != '0) ? S_REQUEUE : S_SORT;
      S_REQUEUE: state_d = S_SORT;
      S_SORT: begin
        cnt_d = cnt_q + IDX_W'(1);
        if (last) begin
          state_d = from_start_q ? S_DONE : S_PICK;
        end
      end
      S_PICK: state_d = S_DONE;
      S_DONE: state_d = out_load ? S_IDLE : S_DONE;
      default: state_d = S_IDLE;
    endcase
  end

  // Handshake, unit mode and list commands
  always_comb begin
    req_i.ready = (state_q == S_IDLE);
    tu_mode     = (state_q == S_CHARGE) ? TU_CHARGE : TU_WALK;
    lcmd        = '{op: L_NOP, odd: 1'b0, id: '0};
    case (state_q)
      S_CLEAR: lcmd.op = L_CLEAR;
      S_LOAD: begin
        lcmd.op = L_INSERT;
        lcmd.id = sel_id;
      end
      S_WALK: begin
        lcmd.op = unit_ins ? L_INSERT : L_NOP;
        lcmd.id = sel_id;
      end
      S_REMOVE: lcmd.op = (cur_q != '0) ? L_POP : L_NOP;
      S_REQUEUE: begin
        lcmd.op = (sel_task.status != TS_BLOCKED) ? L_INSERT : L_NOP;
        lcmd.id = cur_q;
      end
      S_SORT: begin
        lcmd.op  = L_SORT;
        lcmd.odd = cnt_q[0];
      end
      default: lcmd.op = L_NOP;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q <= PERIOD_RST;
      budget_q <= BUDGET_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_PERIOD1: period_q[0] <= cfg_data_i;
        CFG_PERIOD2: period_q[1] <= cfg_data_i;
        CFG_PERIOD3: period_q[2] <= cfg_data_i;
        CFG_BUDGET1: budget_q[0] <= cfg_data_i;
        CFG_BUDGET2: budget_q[1] <= cfg_data_i;
        CFG_BUDGET3: budget_q[2] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Task state, running task and start flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < TASK_SLOTS; i++) begin
        tasks_q[i] <= TASK_RST;
      end
      cur_q        <= '0;
      from_start_q <= 1'b0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            from_start_q <= (op_e == OP_START);
            case (op_e)
              OP_JOB_DONE: begin
                if (sel_task.status == TS_RUNNING) begin
                  tasks_q[sel].status <= TS_BLOCKED;
                end
              end
              OP_SLEEP: begin
                tasks_q[sel].sleep <= req_i.sleep_ticks;
                if (req_i.sleep_ticks != '0) begin
                  tasks_q[sel].status <= TS_BLOCKED;
                end
              end
              OP_EXIT: tasks_q[sel].status <= TS_BLOCKED;
              default: ;
            endcase
          end
        end
        S_CLEAR: begin
          for (int i = 0; i < TASK_SLOTS; i++) begin
            tasks_q[i] <= TASK_RST;
          end
          cur_q <= '0;
        end
        S_LOAD: begin
          tasks_q[sel].period <= task_cfg(period_q, sel_id);
          tasks_q[sel].budget <= task_cfg(budget_q, sel_id);
        end
        S_WALK, S_CHARGE: begin
          tasks_q[sel] <= unit_task;
        end
        S_REQUEUE: begin
          if (sel_task.status != TS_BLOCKED) begin
            tasks_q[sel].status <= TS_READY;
          end
        end
        S_PICK: begin
          cur_q                             <= pick_id;
          tasks_q[pick_id[IDX_W-1:0]].status <= TS_RUNNING;
        end
        default: ;
      endcase
    end
  end

  // Blocked mask over the present slots
  always_comb begin
    mask = '0;
    for (int i = 0; i < TASK_SLOTS; i++) begin
      mask[i] = (tasks_q[i].status == TS_BLOCKED);
    end
  end

  // Hold the result word until taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_task_q  <= cur_q;
      out_count_q <= len;
      out_mask_q  <= mask;
    end
  end

  assign rsp_o.valid        = out_valid_q;
  assign rsp_o.running_task = out_task_q;
  assign rsp_o.ready_count  = out_count_q;
  assign rsp_o.blocked_mask = out_mask_q;

  // Waiting for a word with a real task running
  assign idle_run   = (state_q == S_IDLE) && (cur_q != '0);
  assign cur_status = tasks_q[cur_q[IDX_W-1:0]].status;

  `RMS_ASSERT_ALWAYS(a_len_bound, len <= COUNT_W'(TASK_SLOTS), "list over slot count")
  `RMS_ASSERT(a_head_is_cur, idle_run |-> (len != '0 && head == cur_q), "runner not at head")
  `RMS_ASSERT(a_cur_running, idle_run |-> (cur_status == TS_RUNNING), "runner not marked running")
  `RMS_ASSERT(a_out_from_done, $rose(out_valid_q) |-> $past(state_q == S_DONE), "stray result")

endmodule
